### hdl/pgb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// pgb_pkg
// Types and constants shared by the particle grid binner files.
// ============================================================================
package pgb_pkg;

    localparam int BLOCKS_X_DEF       = 8;
    localparam int BLOCKS_Y_DEF       = 8;
    localparam int BLOCKS_Z_DEF       = 8;
    localparam int BLOCK_CAPACITY_DEF = 16;

    localparam int COORD_W  = 32;
    localparam int ID_W     = 32;
    localparam int RADIUS_W = 31;
    localparam int BIDX_W   = 9;
    localparam int SLOT_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING_Z = 3'd5;

    localparam logic [CFG_DATA_W-1:0] INV_SPACING_RESET = 32'd65536;

    typedef enum logic [1:0] {
        STATUS_STORED  = 2'd0,
        STATUS_OUTSIDE = 2'd1,
        STATUS_FULL    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_OFFSET,
        ST_MULT,
        ST_INDEX,
        ST_WRITE
    } t_state;

endpackage

### hdl/pgb_in_if.sv
`timescale 1ns / 1ps
// ============================================================================
// pgb_in_if
// Particle input channel: one particle per beat.
// ============================================================================
interface pgb_in_if;
    logic                                  valid;
    logic                                  ready;
    logic        [pgb_pkg::ID_W-1:0]       particle_id;
    logic signed [pgb_pkg::COORD_W-1:0]    pos_x;
    logic signed [pgb_pkg::COORD_W-1:0]    pos_y;
    logic signed [pgb_pkg::COORD_W-1:0]    pos_z;
    logic        [pgb_pkg::RADIUS_W-1:0]   radius;

    modport source (output valid, particle_id, pos_x, pos_y, pos_z, radius, input ready);
    modport sink   (input valid, particle_id, pos_x, pos_y, pos_z, radius, output ready);
endinterface

### hdl/pgb_out_if.sv
`timescale 1ns / 1ps
// ============================================================================
// pgb_out_if
// Binning result channel: one result per beat.
// ============================================================================
interface pgb_out_if;
    logic                                  valid;
    logic                                  ready;
    logic        [1:0]                     status;
    logic        [pgb_pkg::BIDX_W-1:0]     block_index;
    logic        [pgb_pkg::SLOT_W-1:0]     slot;
    logic        [pgb_pkg::ID_W-1:0]       out_particle_id;
    logic signed [pgb_pkg::COORD_W-1:0]    out_pos_x;
    logic signed [pgb_pkg::COORD_W-1:0]    out_pos_y;
    logic signed [pgb_pkg::COORD_W-1:0]    out_pos_z;
    logic        [pgb_pkg::RADIUS_W-1:0]   out_radius;
    logic        [pgb_pkg::RADIUS_W-1:0]   largest_radius_so_far;

    modport source (output valid, status, block_index, slot, out_particle_id, out_pos_x,
                    out_pos_y, out_pos_z, out_radius, largest_radius_so_far, input ready);
    modport sink   (input valid, status, block_index, slot, out_particle_id, out_pos_x,
                    out_pos_y, out_pos_z, out_radius, largest_radius_so_far, output ready);
endinterface

### hdl/pgb_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// pgb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module pgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                             i_wr_data,
    input  logic                                         i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                             o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/particle_grid_binner.sv
`timescale 1ns / 1ps
// ============================================================================
// particle_grid_binner
// Sorts particles into the blocks of a uniform 3D grid and hands out slots.
// ============================================================================
// Each particle runs in turn through accept, offset subtract, 32x32 multiply
// per axis, block index and count read, and count write-back with the result
// loaded into the output register (held off while it is full); only then is
// a new particle taken. The block counts live in one RAM. After reset the
// block clears all BLOCKS_X*BLOCKS_Y*BLOCKS_Z counts (512 by default) with
// ready low; configuration writes are taken during it. A finished result may
// wait in the output register while the next particle is taken and worked on.
module particle_grid_binner #(
    parameter int BLOCKS_X       = pgb_pkg::BLOCKS_X_DEF,
    parameter int BLOCKS_Y       = pgb_pkg::BLOCKS_Y_DEF,
    parameter int BLOCKS_Z       = pgb_pkg::BLOCKS_Z_DEF,
    parameter int BLOCK_CAPACITY = pgb_pkg::BLOCK_CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pgb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pgb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    pgb_in_if.sink                             i_in,
    pgb_out_if.source                          o_out
);

    localparam int NUM_BLOCKS = BLOCKS_X * BLOCKS_Y * BLOCKS_Z;
    localparam int LIN_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(BLOCK_CAPACITY + 1);
    localparam logic [LIN_W-1:0] LIN_LAST = LIN_W'(NUM_BLOCKS - 1);
    localparam logic [LIN_W-1:0] MUL_Y    = LIN_W'(BLOCKS_X);
    localparam logic [LIN_W-1:0] MUL_Z    = LIN_W'(BLOCKS_X * BLOCKS_Y);
    localparam logic [CNT_W-1:0] CAP      = CNT_W'(BLOCK_CAPACITY);
    localparam logic [31:0]      LIM_X    = 32'(BLOCKS_X);
    localparam logic [31:0]      LIM_Y    = 32'(BLOCKS_Y);
    localparam logic [31:0]      LIM_Z    = 32'(BLOCKS_Z);

    pgb_pkg::t_state r_state, n_state;

    logic signed [31:0] r_origin_x, r_origin_y, r_origin_z;
    logic        [31:0] r_inv_x, r_inv_y, r_inv_z;

    logic [LIN_W-1:0] r_clr_addr;

    logic        [31:0] r_id;
    logic signed [31:0] r_px, r_py, r_pz;
    logic        [30:0] r_radius;

    logic [31:0] r_off_x, r_off_y, r_off_z;
    logic        r_gt;
    logic [31:0] r_idx_x, r_idx_y, r_idx_z;
    logic [LIN_W-1:0] r_lin;
    logic        r_in_grid;

    logic [30:0] r_largest, n_largest;

    logic                 r_out_valid;
    pgb_pkg::t_status     r_out_status;
    logic [8:0]           r_out_bidx;
    logic [3:0]           r_out_slot;
    logic [31:0]          r_out_id;
    logic signed [31:0]   r_out_px, r_out_py, r_out_pz;
    logic [30:0]          r_out_radius;
    logic [30:0]          r_out_largest;

    logic [32:0]      w_dx, w_dy, w_dz;
    logic             w_gt;
    logic [63:0]      w_prod_x, w_prod_y, w_prod_z;
    logic             w_in_grid;
    logic [LIN_W-1:0] w_lin;
    logic [CNT_W-1:0] w_count;
    logic             w_stored;
    pgb_pkg::t_status w_status;
    logic [31:0]      w_lin32, w_cnt32;
    logic             w_out_free;
    logic             w_in_ready;
    logic             w_done;
    logic             w_rd_en;
    logic             w_wr_en;
    logic [LIN_W-1:0] w_wr_addr;
    logic [CNT_W-1:0] w_wr_data;

    // Datapath arithmetic.
    assign w_dx = {i_in.pos_x[31], i_in.pos_x} - {r_origin_x[31], r_origin_x};
    assign w_dy = {i_in.pos_y[31], i_in.pos_y} - {r_origin_y[31], r_origin_y};
    assign w_dz = {i_in.pos_z[31], i_in.pos_z} - {r_origin_z[31], r_origin_z};
    assign w_gt = (!w_dx[32] && (w_dx != 33'd0)) && (!w_dy[32] && (w_dy != 33'd0))
               && (!w_dz[32] && (w_dz != 33'd0));

    assign w_prod_x = {32'd0, r_off_x} * {32'd0, r_inv_x};
    assign w_prod_y = {32'd0, r_off_y} * {32'd0, r_inv_y};
    assign w_prod_z = {32'd0, r_off_z} * {32'd0, r_inv_z};

    assign w_in_grid = r_gt && (r_idx_x < LIM_X) && (r_idx_y < LIM_Y) && (r_idx_z < LIM_Z);
    assign w_lin = r_idx_x[LIN_W-1:0] + MUL_Y * r_idx_y[LIN_W-1:0]
                 + MUL_Z * r_idx_z[LIN_W-1:0];

    assign w_stored  = r_in_grid && (w_count < CAP);
    assign w_status  = !r_in_grid ? pgb_pkg::STATUS_OUTSIDE
                     : (w_stored ? pgb_pkg::STATUS_STORED : pgb_pkg::STATUS_FULL);
    assign w_lin32   = 32'(r_lin);
    assign w_cnt32   = 32'(w_count);
    assign n_largest = (w_stored && (r_radius > r_largest)) ? r_radius : r_largest;

    assign w_out_free = !r_out_valid || o_out.ready;

    pgb_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_BLOCKS)
    ) u_count_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_lin),
        .o_rd_data (w_count)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            pgb_pkg::ST_CLEAR: begin
                if (r_clr_addr == LIN_LAST) begin
                    n_state = pgb_pkg::ST_IDLE;
                end
            end
            pgb_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = pgb_pkg::ST_OFFSET;
                end
            end
            pgb_pkg::ST_OFFSET: n_state = pgb_pkg::ST_MULT;
            pgb_pkg::ST_MULT:   n_state = pgb_pkg::ST_INDEX;
            pgb_pkg::ST_INDEX:  n_state = pgb_pkg::ST_WRITE;
            pgb_pkg::ST_WRITE: begin
                if (w_out_free) begin
                    n_state = pgb_pkg::ST_IDLE;
                end
            end
            default: n_state = pgb_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        w_in_ready = 1'b0;
        w_done     = 1'b0;
        w_rd_en    = 1'b0;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_lin;
        w_wr_data  = w_count + CNT_W'(1);
        case (r_state)
            pgb_pkg::ST_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr_addr;
                w_wr_data = '0;
            end
            pgb_pkg::ST_IDLE:  w_in_ready = 1'b1;
            pgb_pkg::ST_INDEX: w_rd_en    = w_in_grid;
            pgb_pkg::ST_WRITE: begin
                w_done  = w_out_free;
                w_wr_en = w_out_free && w_stored;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pgb_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_largest   <= '0;
            r_out_valid <= 1'b0;
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_origin_z  <= '0;
            r_inv_x     <= pgb_pkg::INV_SPACING_RESET;
            r_inv_y     <= pgb_pkg::INV_SPACING_RESET;
            r_inv_z     <= pgb_pkg::INV_SPACING_RESET;
        end else begin
            r_state <= n_state;
            if (r_state == pgb_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + LIN_W'(1);
            end
            if (w_done) begin
                r_largest   <= n_largest;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pgb_pkg::CFG_ORIGIN_X:      r_origin_x <= i_cfg_data;
                    pgb_pkg::CFG_ORIGIN_Y:      r_origin_y <= i_cfg_data;
                    pgb_pkg::CFG_ORIGIN_Z:      r_origin_z <= i_cfg_data;
                    pgb_pkg::CFG_INV_SPACING_X: r_inv_x    <= i_cfg_data;
                    pgb_pkg::CFG_INV_SPACING_Y: r_inv_y    <= i_cfg_data;
                    pgb_pkg::CFG_INV_SPACING_Z: r_inv_z    <= i_cfg_data;
                    default: begin
                        r_inv_x <= r_inv_x;
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && w_in_ready) begin
            r_id     <= i_in.particle_id;
            r_px     <= i_in.pos_x;
            r_py     <= i_in.pos_y;
            r_pz     <= i_in.pos_z;
            r_radius <= i_in.radius;
            r_off_x  <= w_dx[31:0];
            r_off_y  <= w_dy[31:0];
            r_off_z  <= w_dz[31:0];
            r_gt     <= w_gt;
        end
        if (r_state == pgb_pkg::ST_MULT) begin
            r_idx_x <= w_prod_x[63:32];
            r_idx_y <= w_prod_y[63:32];
            r_idx_z <= w_prod_z[63:32];
        end
        if (r_state == pgb_pkg::ST_INDEX) begin
            r_lin     <= w_lin;
            r_in_grid <= w_in_grid;
        end
        if (w_done) begin
            r_out_status  <= w_status;
            r_out_bidx    <= w_stored ? w_lin32[8:0] : 9'd0;
            r_out_slot    <= w_stored ? w_cnt32[3:0] : 4'd0;
            r_out_id      <= r_id;
            r_out_px      <= r_px;
            r_out_py      <= r_py;
            r_out_pz      <= r_pz;
            r_out_radius  <= r_radius;
            r_out_largest <= n_largest;
        end
    end

    // The operands the multiply stage uses are registered at acceptance:
    // offsets are taken from the input beat directly.

    assign i_in.ready                  = w_in_ready;
    assign o_out.valid                 = r_out_valid;
    assign o_out.status                = r_out_status;
    assign o_out.block_index           = r_out_bidx;
    assign o_out.slot                  = r_out_slot;
    assign o_out.out_particle_id       = r_out_id;
    assign o_out.out_pos_x             = r_out_px;
    assign o_out.out_pos_y             = r_out_py;
    assign o_out.out_pos_z             = r_out_pz;
    assign o_out.out_radius            = r_out_radius;
    assign o_out.largest_radius_so_far = r_out_largest;

`ifndef SYNTHESIS
    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == pgb_pkg::ST_OFFSET))
        else $error("accepted beat did not start the offset stage");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (w_wr_data <= CAP))
        else $error("block count written above capacity");

    a_unstored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != pgb_pkg::STATUS_STORED))
            |-> ((r_out_bidx == 9'd0) && (r_out_slot == 4'd0)))
        else $error("unstored result carries a block index or slot");

    a_largest_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_largest >= $past(r_largest)))
        else $error("largest radius decreased");
`endif

endmodule
